[rtl/pixel_average_gamma_quantizer_defines.svh]
`ifndef PIXEL_AVERAGE_GAMMA_QUANTIZER_DEFINES_SVH
`define PIXEL_AVERAGE_GAMMA_QUANTIZER_DEFINES_SVH

// check a condition in the same cycle
`define PAGQ_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the next cycle
`define PAGQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pagq_pkg.sv]
package pagq_pkg;

    localparam int LOG_FRAC          = 20;
    localparam int GAMMA_FRAC        = 14;
    localparam int LUT_W             = 24;
    localparam int LANE_FIXED_STAGES = 31;

    localparam logic REG_SAMPLE_COUNT  = 1'b0;
    localparam logic REG_INVERSE_GAMMA = 1'b1;

    localparam logic [15:0] SAMPLE_COUNT_RESET  = 16'd1;
    localparam logic [15:0] INVERSE_GAMMA_RESET = 16'd7447;

    typedef enum logic [1:0] {
        LVL_CALC,
        LVL_ZERO,
        LVL_FULL
    } lvl_kind_t;

    typedef struct packed {
        logic signed [31:0] sum_red;
        logic signed [31:0] sum_green;
        logic signed [31:0] sum_blue;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [2:0] negative_mask;
    } out_word_t;

    typedef struct packed {
        logic [15:0] sample_count;
        logic [15:0] inverse_gamma;
    } lane_cfg_t;

    function automatic logic [LOG_FRAC+2:0] level_log2(input logic [7:0] v);
        logic [63:0]         y;
        logic [LOG_FRAC-1:0] frac;
        logic [2:0]          n;
        n = '0;
        for (int i = 1; i < 8; i++) begin
            if (v[i]) n = 3'(i);
        end
        y = 64'(v) << (30 - int'(n));
        frac = '0;
        for (int i = 0; i < LOG_FRAC; i++) begin
            y = (y * y) >> 30;
            frac = {frac[LOG_FRAC-2:0], 1'b0};
            if (y >= 64'h8000_0000) begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        return {n, frac};
    endfunction

    function automatic logic signed [LUT_W-1:0] level_log_rel(input logic [7:0] v);
        return $signed({1'b0, level_log2(v)}) - $signed({1'b0, level_log2(8'd255)});
    endfunction

endpackage

[rtl/pagq_div_stage.sv]
module pagq_div_stage import pagq_pkg::*; #(
    parameter int ACC_FRAC_BITS = 16,
    parameter int BIT           = 0
) (
    input  logic                     aclk,
    input  logic                     ld,
    input  logic [30:0]              rem_i,
    input  logic [ACC_FRAC_BITS-1:0] quo_i,
    input  logic [15:0]              div_i,
    output logic [30:0]              rem_o,
    output logic [ACC_FRAC_BITS-1:0] quo_o
);

    localparam int CW = (ACC_FRAC_BITS + 16 > 31) ? ACC_FRAC_BITS + 16 : 31;

    logic [CW-1:0] rem_w;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff_w;
    logic          take;

    always_comb begin
        rem_w  = CW'(rem_i);
        dsh    = CW'(div_i) << BIT;
        take   = rem_w >= dsh;
        diff_w = rem_w - dsh;
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            rem_o <= take ? diff_w[30:0] : rem_i;
            quo_o <= take ? (quo_i | (ACC_FRAC_BITS'(1) << BIT)) : quo_i;
        end
    end

endmodule

[rtl/pagq_log_stage.sv]
module pagq_log_stage import pagq_pkg::*; (
    input  logic                aclk,
    input  logic                ld,
    input  logic [30:0]         y_i,
    input  logic [LOG_FRAC-1:0] frac_i,
    output logic [30:0]         y_o,
    output logic [LOG_FRAC-1:0] frac_o
);

    logic [61:0] prod;
    logic [31:0] sq;

    always_comb begin
        prod = 62'(y_i) * 62'(y_i);
        sq   = prod[61:30];
    end

    always_ff @(posedge aclk) begin
        if (ld) begin
            if (sq[31]) begin
                y_o    <= sq[31:1];
                frac_o <= {frac_i[LOG_FRAC-2:0], 1'b1};
            end else begin
                y_o    <= sq[30:0];
                frac_o <= {frac_i[LOG_FRAC-2:0], 1'b0};
            end
        end
    end

endmodule

[rtl/pagq_lane.sv]
module pagq_lane import pagq_pkg::*; #(
    parameter int ACC_FRAC_BITS = 16
) (
    input  logic                                       aclk,
    input  logic [ACC_FRAC_BITS+LANE_FIXED_STAGES-1:0] stage_ld,
    input  lane_cfg_t                                  cfg,
    input  logic signed [31:0]                         sum_in,
    output logic [7:0]                                 level,
    output logic                                       negative
);

    localparam int F       = ACC_FRAC_BITS;
    localparam int DEPTH   = F + LANE_FIXED_STAGES;
    localparam int S_NORM  = F + 1;
    localparam int S_LOG0  = F + 2;
    localparam int S_RHS   = F + 22;
    localparam int S_SRCH0 = F + 23;
    localparam int NW      = $clog2(F + 1);
    localparam int DIFW    = NW + 22;
    localparam int RW      = DIFW + 17;
    localparam int CW      = (F + 16 > 31) ? F + 16 : 31;

    logic signed [LUT_W-1:0] lvl_lut [256];

    logic [30:0]         rem_q   [0:F-1];
    logic [F-1:0]        quo_q   [0:F];
    logic [15:0]         div_q   [0:F-1];
    logic                clamp_q [0:F];
    logic                neg_q   [0:DEPTH-1];
    lvl_kind_t           kind_q  [S_NORM:DEPTH-1];
    logic [NW-1:0]       n_q     [S_NORM:S_RHS-1];
    logic [30:0]         y_q     [S_NORM:S_RHS-2];
    logic [LOG_FRAC-1:0] frac_q  [S_NORM:S_RHS-1];
    logic signed [RW-1:0] rhs_q  [S_RHS:DEPTH-2];
    logic [7:0]          res_q   [S_RHS:DEPTH-1];

    logic [15:0]            div_next;
    logic [F:0]             avg_w;
    logic [NW-1:0]          msb;
    logic [30:0]            y_norm;
    lvl_kind_t              kind_next;
    logic [NW+LOG_FRAC-1:0] lm;
    logic signed [DIFW-1:0] diff;
    logic signed [RW-1:0]   rhs_next;

    for (genvar g = 0; g < 256; g++) begin : g_lut
        assign lvl_lut[g] = level_log_rel(8'(g));
    end

    always_comb begin
        div_next = (cfg.sample_count == '0) ? 16'd1 : cfg.sample_count;
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[0]) begin
            rem_q[0]   <= sum_in[30:0];
            quo_q[0]   <= '0;
            div_q[0]   <= div_next;
            neg_q[0]   <= sum_in[31];
            clamp_q[0] <= CW'(sum_in[30:0]) >= (CW'(div_next) << F);
        end
    end

    for (genvar s = 1; s <= F; s++) begin : g_div
        if (s < F) begin : g_mid
            pagq_div_stage #(.ACC_FRAC_BITS(F), .BIT(F - s)) u_div (
                .aclk  (aclk),
                .ld    (stage_ld[s]),
                .rem_i (rem_q[s-1]),
                .quo_i (quo_q[s-1]),
                .div_i (div_q[s-1]),
                .rem_o (rem_q[s]),
                .quo_o (quo_q[s])
            );
            always_ff @(posedge aclk) begin
                if (stage_ld[s]) div_q[s] <= div_q[s-1];
            end
        end else begin : g_last
            pagq_div_stage #(.ACC_FRAC_BITS(F), .BIT(0)) u_div (
                .aclk  (aclk),
                .ld    (stage_ld[s]),
                .rem_i (rem_q[s-1]),
                .quo_i (quo_q[s-1]),
                .div_i (div_q[s-1]),
                .rem_o (),
                .quo_o (quo_q[s])
            );
        end
        always_ff @(posedge aclk) begin
            if (stage_ld[s]) begin
                neg_q[s]   <= neg_q[s-1];
                clamp_q[s] <= clamp_q[s-1];
            end
        end
    end

    always_comb begin
        avg_w = clamp_q[F] ? {1'b1, {F{1'b0}}} : {1'b0, quo_q[F]};
        msb   = '0;
        for (int i = 0; i <= F; i++) begin
            if (avg_w[i]) msb = NW'(i);
        end
        y_norm = 31'(avg_w) << (5'd30 - 5'(msb));
        if (neg_q[F]) begin
            kind_next = LVL_ZERO;
        end else if (cfg.inverse_gamma == '0) begin
            kind_next = LVL_FULL;
        end else if (avg_w == '0) begin
            kind_next = LVL_ZERO;
        end else begin
            kind_next = LVL_CALC;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[S_NORM]) begin
            neg_q[S_NORM]  <= neg_q[F];
            kind_q[S_NORM] <= kind_next;
            n_q[S_NORM]    <= msb;
            y_q[S_NORM]    <= y_norm;
            frac_q[S_NORM] <= '0;
        end
    end

    for (genvar j = 0; j < LOG_FRAC; j++) begin : g_log
        localparam int I = S_LOG0 + j;
        if (j < LOG_FRAC - 1) begin : g_mid
            pagq_log_stage u_log (
                .aclk   (aclk),
                .ld     (stage_ld[I]),
                .y_i    (y_q[I-1]),
                .frac_i (frac_q[I-1]),
                .y_o    (y_q[I]),
                .frac_o (frac_q[I])
            );
        end else begin : g_last
            pagq_log_stage u_log (
                .aclk   (aclk),
                .ld     (stage_ld[I]),
                .y_i    (y_q[I-1]),
                .frac_i (frac_q[I-1]),
                .y_o    (),
                .frac_o (frac_q[I])
            );
        end
        always_ff @(posedge aclk) begin
            if (stage_ld[I]) begin
                neg_q[I]  <= neg_q[I-1];
                kind_q[I] <= kind_q[I-1];
                n_q[I]    <= n_q[I-1];
            end
        end
    end

    always_comb begin
        lm       = {n_q[S_RHS-1], frac_q[S_RHS-1]};
        diff     = $signed(DIFW'(lm)) - $signed(DIFW'(F) << LOG_FRAC);
        rhs_next = $signed({1'b0, cfg.inverse_gamma}) * diff;
    end

    always_ff @(posedge aclk) begin
        if (stage_ld[S_RHS]) begin
            neg_q[S_RHS]  <= neg_q[S_RHS-1];
            kind_q[S_RHS] <= kind_q[S_RHS-1];
            rhs_q[S_RHS]  <= rhs_next;
            res_q[S_RHS]  <= '0;
        end
    end

    for (genvar j = 0; j < 8; j++) begin : g_srch
        localparam int I = S_SRCH0 + j;
        logic [7:0]                           t;
        logic signed [LUT_W+GAMMA_FRAC-1:0]   lhs;
        logic signed [RW-1:0]                 lhs_ext;
        always_comb begin
            t       = res_q[I-1] | (8'd1 << (7 - j));
            lhs     = {lvl_lut[t], {GAMMA_FRAC{1'b0}}};
            lhs_ext = RW'(lhs);
        end
        always_ff @(posedge aclk) begin
            if (stage_ld[I]) begin
                neg_q[I]  <= neg_q[I-1];
                kind_q[I] <= kind_q[I-1];
                res_q[I]  <= (lhs_ext <= rhs_q[I-1]) ? t : res_q[I-1];
            end
        end
        if (j < 7) begin : g_fwd
            always_ff @(posedge aclk) begin
                if (stage_ld[I]) rhs_q[I] <= rhs_q[I-1];
            end
        end
    end

    always_comb begin
        case (kind_q[DEPTH-1])
            LVL_FULL: level = 8'd255;
            LVL_ZERO: level = 8'd0;
            LVL_CALC: level = res_q[DEPTH-1];
            default:  level = 8'd0;
        endcase
        negative = neg_q[DEPTH-1];
    end

endmodule

[rtl/pixel_average_gamma_quantizer.sv]
// One pixel word is accepted per clock and one result word leaves per clock when
// the output side keeps up. Red, green and blue run in three identical lanes; the
// divider resolves one quotient bit per stage, and the log2 unit squares once per
// stage for each of its 20 fraction bits. A stalled output lets the pipeline keep
// filling until every stage holds a word.
// sample_count sits at address 0x0 and inverse_gamma at 0x4; write them only while
// no words are in flight.
`include "pixel_average_gamma_quantizer_defines.svh"

module pixel_average_gamma_quantizer import pagq_pkg::*; #(
    parameter int ACC_FRAC_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = ACC_FRAC_BITS + LANE_FIXED_STAGES;

    logic [15:0] sample_count_reg, sample_count_next;
    logic [15:0] inverse_gamma_reg, inverse_gamma_next;
    logic [DEPTH-1:0] vld_reg, vld_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;

    logic [DEPTH:0]   adv;
    logic [DEPTH-1:0] vld_in;
    lane_cfg_t        cfg;
    logic [7:0]       lvl_r, lvl_g, lvl_b;
    logic             neg_r, neg_g, neg_b;

    always_comb begin
        sample_count_next  = sample_count_reg;
        inverse_gamma_next = inverse_gamma_reg;
        if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_SAMPLE_COUNT:  sample_count_next  = pwdata[15:0];
                REG_INVERSE_GAMMA: inverse_gamma_next = pwdata[15:0];
                default: ;
            endcase
        end
        case (paddr[2])
            REG_SAMPLE_COUNT:  prdata = {16'd0, sample_count_reg};
            REG_INVERSE_GAMMA: prdata = {16'd0, inverse_gamma_reg};
            default:           prdata = '0;
        endcase
        pready = 1'b1;
        cfg.sample_count  = sample_count_reg;
        cfg.inverse_gamma = inverse_gamma_reg;
    end

    always_comb begin
        adv[DEPTH] = !m_valid_reg || m_ready;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
        vld_in   = {vld_reg[DEPTH-2:0], s_valid};
        vld_next = vld_reg;
        for (int i = 0; i < DEPTH; i++) begin
            if (adv[i]) vld_next[i] = vld_in[i];
        end
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv[DEPTH]) begin
            m_valid_next = vld_reg[DEPTH-1];
            m_data_next.red_level     = lvl_r;
            m_data_next.green_level   = lvl_g;
            m_data_next.blue_level    = lvl_b;
            m_data_next.negative_mask = {neg_b, neg_g, neg_r};
        end
        s_ready = adv[0];
        m_valid = m_valid_reg;
        m_data  = m_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg  <= SAMPLE_COUNT_RESET;
            inverse_gamma_reg <= INVERSE_GAMMA_RESET;
            vld_reg           <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            sample_count_reg  <= sample_count_next;
            inverse_gamma_reg <= inverse_gamma_next;
            vld_reg           <= vld_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    pagq_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_lane_red (
        .aclk     (aclk),
        .stage_ld (adv[DEPTH-1:0]),
        .cfg      (cfg),
        .sum_in   (s_data.sum_red),
        .level    (lvl_r),
        .negative (neg_r)
    );

    pagq_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_lane_green (
        .aclk     (aclk),
        .stage_ld (adv[DEPTH-1:0]),
        .cfg      (cfg),
        .sum_in   (s_data.sum_green),
        .level    (lvl_g),
        .negative (neg_g)
    );

    pagq_lane #(.ACC_FRAC_BITS(ACC_FRAC_BITS)) u_lane_blue (
        .aclk     (aclk),
        .stage_ld (adv[DEPTH-1:0]),
        .cfg      (cfg),
        .sum_in   (s_data.sum_blue),
        .level    (lvl_b),
        .negative (neg_b)
    );

    `PAGQ_ASSERT_IMPLIES(a_neg_red_zero, aclk, aresetn, m_valid && m_data.negative_mask[0], m_data.red_level == 8'd0, "negative red channel with nonzero level")
    `PAGQ_ASSERT_NEXT(a_no_phantom_word, aclk, aresetn, vld_reg == '0 && !m_valid_reg, !m_valid_reg, "result word without an input word")
    `PAGQ_ASSERT_IMPLIES(a_ready_when_drained, aclk, aresetn, !m_valid_reg, s_ready, "input stalled with empty output register")

endmodule
